FILE: rtl/isp_pkg.sv
// ----------------------------------------------------------------------------
// isp_pkg
// Shared constants and types of the iterated three-point smoother.
// ----------------------------------------------------------------------------
package isp_pkg;

	localparam int ISP_MAX_PASSES  = 16;
	localparam int ISP_SAMPLE_BITS = 16;
	localparam int ISP_PASS_BITS   = 5;
	localparam int ISP_PASS_RESET  = 1;

	typedef struct packed {
		logic clear;
		logic enable;
	} isp_cell_ctl_t;

endpackage

FILE: rtl/isp_cell.sv
// ----------------------------------------------------------------------------
// isp_cell
// One smoothing pass: holds the centre sample and its left neighbour, emits
// the truncated three-point average one sample late, replicates the edge
// sample at both block ends, and forwards beats unchanged when disabled.
// ----------------------------------------------------------------------------
module isp_cell #(
	parameter int SAMPLE_BITS = isp_pkg::ISP_SAMPLE_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  isp_pkg::isp_cell_ctl_t        ctl,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [SAMPLE_BITS-1:0] in_data,
	input  logic                          in_last,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [SAMPLE_BITS-1:0] out_data,
	output logic                          out_last
);
	import isp_pkg::*;

	localparam int SUM_BITS = SAMPLE_BITS + 2;
	localparam int MAG_BITS = SAMPLE_BITS + 1;
	localparam logic [MAG_BITS:0]   POW   = (MAG_BITS + 1)'(1) << MAG_BITS;
	localparam logic [MAG_BITS-1:0] RECIP = MAG_BITS'(POW / 3);

	logic                          occ_q;
	logic                          flush_q;
	logic                          ov_q;
	logic signed [SAMPLE_BITS-1:0] held_q;
	logic signed [SAMPLE_BITS-1:0] left_q;
	logic signed [SAMPLE_BITS-1:0] od_q;
	logic                          ol_q;

	logic                          load_ok;
	logic                          in_fire;
	logic                          emit;
	logic                          emit_last;
	logic signed [SAMPLE_BITS-1:0] emit_data;
	logic signed [SAMPLE_BITS-1:0] right;
	logic signed [SUM_BITS-1:0]    sum;
	logic [MAG_BITS-1:0]           mag;
	logic [2*MAG_BITS-1:0]         prod;
	logic [MAG_BITS-1:0]           q0;
	logic [MAG_BITS:0]             trip;
	logic [MAG_BITS:0]             rem;
	logic [MAG_BITS-1:0]           quo;
	logic signed [SAMPLE_BITS-1:0] avg;

	// average of three, truncated toward zero
	always_comb begin
		right = flush_q ? held_q : in_data;
		sum   = SUM_BITS'(left_q) + SUM_BITS'(held_q) + SUM_BITS'(right);
		mag   = sum[SUM_BITS-1] ? MAG_BITS'(-sum) : MAG_BITS'(sum);
		prod  = {{MAG_BITS{1'b0}}, mag} * {{MAG_BITS{1'b0}}, RECIP};
		q0    = prod[2*MAG_BITS-1:MAG_BITS];
		trip  = {q0, 1'b0} + {1'b0, q0};
		rem   = {1'b0, mag} - trip;
		quo   = (rem >= (MAG_BITS + 1)'(3)) ? q0 + MAG_BITS'(1) : q0;
		avg   = sum[SUM_BITS-1] ? SAMPLE_BITS'(-quo) : SAMPLE_BITS'(quo);
	end

	always_comb begin
		load_ok  = !ov_q || out_ready;
		in_ready = load_ok && !flush_q;
		in_fire  = in_valid && in_ready;
		if (flush_q) begin
			emit      = load_ok;
			emit_last = 1'b1;
			emit_data = avg;
		end else begin
			emit      = in_fire && (!ctl.enable || occ_q || in_last);
			emit_last = in_last && (!ctl.enable || !occ_q);
			emit_data = (ctl.enable && occ_q) ? avg : in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q   <= 1'b0;
			flush_q <= 1'b0;
			ov_q    <= 1'b0;
		end else if (ctl.clear) begin
			occ_q   <= 1'b0;
			flush_q <= 1'b0;
			ov_q    <= 1'b0;
		end else begin
			if (flush_q && load_ok) begin
				flush_q <= 1'b0;
				occ_q   <= 1'b0;
			end else if (in_fire && ctl.enable) begin
				if (occ_q) begin
					flush_q <= in_last;
				end else begin
					occ_q <= !in_last;
				end
			end
			if (emit) begin
				ov_q <= 1'b1;
			end else if (out_ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && ctl.enable) begin
			if (occ_q) begin
				left_q <= held_q;
			end else begin
				left_q <= in_data;
			end
			held_q <= in_data;
		end
		if (emit) begin
			od_q <= emit_data;
			ol_q <= emit_last;
		end
	end

	assign out_valid = ov_q;
	assign out_data  = od_q;
	assign out_last  = ol_q;

endmodule

FILE: rtl/iterated_three_point_smoother.sv
// ----------------------------------------------------------------------------
// iterated_three_point_smoother
// Chain of three-point averaging cells applied to blocks of audio samples.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one signed sample per beat, tlast on the final sample of a
//   block. m_axis returns the smoothed samples in block order, tlast on the
//   final one. cfg_we/cfg_wdata write pass_count (0..16, larger saturates);
//   a write clears every cell; the user must make it only while the block is
//   idle, which the block itself does not enforce. Each of the MAX_PASSES
//   cells adds one register stage; an enabled cell also holds one sample of
//   lookahead, so a beat passes every cell register to reach m_axis and also
//   waits for one more sample per enabled pass. The chain takes one beat per
//   cycle while m_axis is ready and no cell flushes. A tlast beat makes each
//   enabled cell emit two beats (one for a one-sample block), so s_axis_tready
//   drops while the tail drains; the block has left once the chain drains.
//   Reset sets pass_count to 1 and empties all cells. A stall on m_axis
//   backs up through the cell registers to s_axis_tready; no beat is lost.
// ----------------------------------------------------------------------------
module iterated_three_point_smoother #(
	parameter int MAX_PASSES  = isp_pkg::ISP_MAX_PASSES,
	parameter int SAMPLE_BITS = isp_pkg::ISP_SAMPLE_BITS,
	parameter int TDATA_BITS  = ((SAMPLE_BITS + 7) / 8) * 8
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [isp_pkg::ISP_PASS_BITS-1:0]  cfg_wdata,   // pass_count
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	input  logic [TDATA_BITS-1:0]              s_axis_tdata,  // sample_in
	input  logic                               s_axis_tlast,  // block_end
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	output logic [TDATA_BITS-1:0]              m_axis_tdata,  // sample_out
	output logic                               m_axis_tlast   // out_last
);
	import isp_pkg::*;

	localparam int CNT_BITS = $clog2(MAX_PASSES + 1);
	localparam int CW       = (CNT_BITS > ISP_PASS_BITS) ? CNT_BITS : ISP_PASS_BITS;

	logic [ISP_PASS_BITS-1:0] pass_q;
	logic [CW-1:0]            pass_ext;
	logic [CW-1:0]            pass_sat;
	logic [MAX_PASSES-1:0]    cell_en;

	logic                          lv [MAX_PASSES+1];
	logic                          lr [MAX_PASSES+1];
	logic signed [SAMPLE_BITS-1:0] ld [MAX_PASSES+1];
	logic                          ll [MAX_PASSES+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pass_q <= ISP_PASS_BITS'(ISP_PASS_RESET);
		end else if (cfg_we) begin
			pass_q <= cfg_wdata;
		end
	end

	always_comb begin
		pass_ext = CW'(pass_q);
		pass_sat = (pass_ext > CW'(MAX_PASSES)) ? CW'(MAX_PASSES) : pass_ext;
	end

	assign lv[0]         = s_axis_tvalid;
	assign s_axis_tready = lr[0];
	assign ld[0]         = s_axis_tdata[SAMPLE_BITS-1:0];
	assign ll[0]         = s_axis_tlast;

	for (genvar i = 0; i < MAX_PASSES; i++) begin : g_cell
		isp_cell_ctl_t ctl;

		assign cell_en[i] = CW'(i) < pass_sat;
		// clear in the upper bit, enable in the lower
		assign ctl        = {cfg_we, cell_en[i]};

		isp_cell #(
			.SAMPLE_BITS(SAMPLE_BITS)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.in_valid (lv[i]),
			.in_ready (lr[i]),
			.in_data  (ld[i]),
			.in_last  (ll[i]),
			.out_valid(lv[i+1]),
			.out_ready(lr[i+1]),
			.out_data (ld[i+1]),
			.out_last (ll[i+1])
		);
	end

	assign m_axis_tvalid       = lv[MAX_PASSES];
	assign lr[MAX_PASSES]      = m_axis_tready;
	assign m_axis_tdata        = TDATA_BITS'(unsigned'(ld[MAX_PASSES]));
	assign m_axis_tlast        = ll[MAX_PASSES];

`ifndef NO_ASSERTIONS
	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> !m_axis_tvalid)
		else $error("chain not emptied by register write");

	a_enable_count: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(cell_en) == 32'(pass_sat))
		else $error("enabled cell count differs from pass count");

	a_enable_thermo: assert property (@(posedge clk) disable iff (!arst_n)
		(cell_en & (cell_en + MAX_PASSES'(1))) == '0)
		else $error("enabled cells not contiguous from the input");
`endif

endmodule

FILE: dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the iterated three-point smoother.
// Blocks of signed samples go in on s_axis. A cycle-free predictor of the
// cell chain computes every smoothed beat. Each m_axis beat is checked
// against the oldest predicted one. The directed tests cover the sample
// extremes, the reset pass count, one-sample blocks, zero passes,
// truncation toward zero, saturated pass counts and an abandoned block.
// Random blocks then run under four phases of source idling and sink
// stalling, with the pass count rewritten between blocks and after partial ones.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import isp_pkg::*;

	localparam int SAMPLE_W      = ISP_SAMPLE_BITS;
	localparam int SETTLE_CYCLES = 2 * ISP_MAX_PASSES + 8;
	localparam int CYCLE_LIMIT   = 200000;
	localparam int RANDOM_ITEMS  = 220;

	typedef struct {
		logic [SAMPLE_W-1:0] sample;
		logic                last;
	} smoothed_t;

	logic                     clk           = 1'b0;
	logic                     arst_n        = 1'b0;
	logic                     cfg_we        = 1'b0;
	logic [ISP_PASS_BITS-1:0] cfg_wdata     = '0;
	logic                     s_axis_tvalid = 1'b0;
	logic                     s_axis_tready;
	logic [SAMPLE_W-1:0]      s_axis_tdata  = '0;  // sample_in
	logic                     s_axis_tlast  = 1'b0; // block_end
	logic                     m_axis_tvalid;
	logic                     m_axis_tready = 1'b0;
	logic [SAMPLE_W-1:0]      m_axis_tdata;        // sample_out
	logic                     m_axis_tlast;        // out_last

	logic [ISP_PASS_BITS-1:0] model_passes;
	logic signed [SAMPLE_W-1:0] held_sample [ISP_MAX_PASSES];
	logic signed [SAMPLE_W-1:0] left_sample [ISP_MAX_PASSES];
	bit                         cell_busy   [ISP_MAX_PASSES];

	smoothed_t pending_smoothed[$];
	smoothed_t next_smoothed;

	int src_idle_pct   = 0;
	int sink_stall_pct = 0;
	int mismatches     = 0;
	int samples_sent   = 0;
	int blocks_sent    = 0;
	int beats_checked  = 0;
	int pass_writes    = 0;
	int cycle_count    = 0;

	iterated_three_point_smoother uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("timeout after %0d cycles, %0d beats still due", cycle_count,
			pending_smoothed.size());
		$display("end of test: mismatches");
		$finish;
	end

	always @(negedge clk) begin
		m_axis_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
	end

	task automatic report_mismatch(input string what, input logic [31:0] want,
			input logic [31:0] got);
		mismatches++;
		if (mismatches <= 40)
			$display("mismatch %s at beat %0d: expected %0h, got %0h", what,
				beats_checked, want, got);
	endtask

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_smoothed.size() == 0) begin
				report_mismatch("unexpected beat", 32'h0, {15'h0, m_axis_tlast, m_axis_tdata});
			end else begin
				next_smoothed = pending_smoothed.pop_front();
				if (m_axis_tdata !== next_smoothed.sample)
					report_mismatch("sample_out", 32'(next_smoothed.sample),
						32'(m_axis_tdata));
				if (m_axis_tlast !== next_smoothed.last)
					report_mismatch("out_last", 32'(next_smoothed.last), 32'(m_axis_tlast));
			end
			beats_checked++;
		end
	end

	function automatic logic signed [SAMPLE_W-1:0] average3(input int a, input int b,
			input int c);
		return SAMPLE_W'((a + b + c) / 3);
	endfunction

	task automatic clear_cells();
		for (int c = 0; c < ISP_MAX_PASSES; c++) begin
			held_sample[c] = '0;
			left_sample[c] = '0;
			cell_busy[c]   = 1'b0;
		end
	endtask

	task automatic smooth_sample(input logic [SAMPLE_W-1:0] raw, input logic last);
		logic signed [SAMPLE_W-1:0] cur_v[$];
		logic signed [SAMPLE_W-1:0] nxt_v[$];
		bit                         cur_l[$];
		bit                         nxt_l[$];
		smoothed_t                  beat;
		int                         passes;
		passes = (model_passes > ISP_MAX_PASSES) ? ISP_MAX_PASSES : model_passes;
		cur_v.push_back(raw);
		cur_l.push_back(last);
		for (int c = 0; c < passes; c++) begin
			nxt_v.delete();
			nxt_l.delete();
			for (int k = 0; k < cur_v.size(); k++) begin
				if (cell_busy[c]) begin
					nxt_v.push_back(average3(left_sample[c], held_sample[c], cur_v[k]));
					nxt_l.push_back(1'b0);
					left_sample[c] = held_sample[c];
					held_sample[c] = cur_v[k];
				end else begin
					left_sample[c] = cur_v[k];
					held_sample[c] = cur_v[k];
					cell_busy[c]   = 1'b1;
				end
				if (cur_l[k]) begin
					nxt_v.push_back(average3(left_sample[c], held_sample[c], held_sample[c]));
					nxt_l.push_back(1'b1);
					cell_busy[c] = 1'b0;
				end
			end
			cur_v = nxt_v;
			cur_l = nxt_l;
		end
		for (int k = 0; k < cur_v.size(); k++) begin
			beat.sample = cur_v[k];
			beat.last   = cur_l[k];
			pending_smoothed.push_back(beat);
		end
	endtask

	task automatic send_sample(input logic [SAMPLE_W-1:0] sample, input logic last);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			@(negedge clk);
			s_axis_tvalid <= 1'b0;
		end
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= sample;
		s_axis_tlast  <= last;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		smooth_sample(sample, last);
		samples_sent++;
		if (last)
			blocks_sent++;
	endtask

	task automatic drain_chain();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (pending_smoothed.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_pass_count(input logic [ISP_PASS_BITS-1:0] value);
		drain_chain();
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		model_passes = value;
		clear_cells();
		pass_writes++;
	endtask

	function automatic logic [SAMPLE_W-1:0] pick_sample();
		case ($urandom_range(0, 9))
			0: return 16'h7FFF;
			1: return 16'h8000;
			2: return SAMPLE_W'($signed($urandom_range(0, 6)) - 3);
			default: return SAMPLE_W'($urandom);
		endcase
	endfunction

	function automatic logic [ISP_PASS_BITS-1:0] pick_pass_count();
		case ($urandom_range(0, 9))
			0: return ISP_PASS_BITS'(ISP_MAX_PASSES);
			1: return ISP_PASS_BITS'($urandom_range(ISP_MAX_PASSES + 1, 31));
			2: return '0;
			default: return ISP_PASS_BITS'($urandom_range(1, 5));
		endcase
	endfunction

	task automatic test_reset_pass_count();
		send_sample(16'h7FFF, 1'b0);
		send_sample(16'h8000, 1'b0);
		send_sample(16'h7FFF, 1'b1);
	endtask

	task automatic test_one_sample_blocks();
		send_sample(16'h8000, 1'b1);
		write_pass_count(ISP_PASS_BITS'(ISP_MAX_PASSES));
		send_sample(16'h7FFF, 1'b1);
	endtask

	task automatic test_zero_passes();
		write_pass_count('0);
		send_sample(16'hA5A5, 1'b0);
		send_sample(16'h5A5A, 1'b1);
	endtask

	task automatic test_truncation();
		write_pass_count(ISP_PASS_BITS'(1));
		send_sample(16'hFFFF, 1'b0);
		send_sample(16'hFFFF, 1'b0);
		send_sample(16'h0000, 1'b1);
	endtask

	task automatic test_saturated_passes();
		write_pass_count(ISP_PASS_BITS'(ISP_MAX_PASSES));
		send_sample(16'h7FFF, 1'b0);
		send_sample(16'h8000, 1'b0);
		send_sample(16'h0001, 1'b0);
		send_sample(16'hFFFE, 1'b1);
		write_pass_count('1);
		send_sample(16'h8000, 1'b0);
		send_sample(16'h7FFF, 1'b0);
		send_sample(16'h8000, 1'b1);
	endtask

	task automatic test_abandoned_block();
		write_pass_count(ISP_PASS_BITS'(2));
		send_sample(16'h1234, 1'b0);
		send_sample(16'hEDCB, 1'b0);
		write_pass_count(ISP_PASS_BITS'(3));
		send_sample(16'h0100, 1'b0);
		send_sample(16'hFF00, 1'b1);
	endtask

	task automatic test_random_blocks();
		int quota;
		int sent;
		int len;
		quota = RANDOM_ITEMS / 4;
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
				1: begin src_idle_pct = 63; sink_stall_pct = 0;  end
				2: begin src_idle_pct = 0;  sink_stall_pct = 63; end
				default: begin src_idle_pct = 14; sink_stall_pct = 14; end
			endcase
			write_pass_count(pick_pass_count());
			sent = 0;
			while (sent < quota) begin
				if ($urandom_range(0, 7) == 0)
					write_pass_count(pick_pass_count());
				if ($urandom_range(0, 19) == 0) begin
					len = $urandom_range(1, 3);
					for (int k = 0; k < len; k++)
						send_sample(pick_sample(), 1'b0);
					sent += len;
					write_pass_count(pick_pass_count());
				end
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 6);
				for (int k = 0; k < len; k++)
					send_sample(pick_sample(), k == len - 1);
				sent += len;
			end
		end
	endtask

	initial begin
		model_passes = ISP_PASS_BITS'(ISP_PASS_RESET);
		clear_cells();
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;

		test_reset_pass_count();
		test_one_sample_blocks();
		test_zero_passes();
		test_truncation();
		test_saturated_passes();
		test_abandoned_block();
		test_random_blocks();

		drain_chain();
		$display("sent %0d samples in %0d blocks, checked %0d smoothed beats", samples_sent,
			blocks_sent, beats_checked);
		$display("pass count rewritten %0d times across 0..31, four idle/stall phases",
			pass_writes);
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
